>>> src/itp_pkg.sv
// Package for the infix-to-postfix converter: item types, status codes and
// character classification. Depends on nothing.
`timescale 1ns / 1ps

package itp_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic [1:0] status;
    logic       done_res;
  } out_item_t;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusOverflow = 2'd1;
  localparam logic [1:0] StatusNoOpen   = 2'd2;
  localparam logic [1:0] StatusNoClose  = 2'd3;

  localparam logic [7:0] ChOpen  = 8'h28;  // (
  localparam logic [7:0] ChClose = 8'h29;  // )
  localparam logic [7:0] ChMul   = 8'h2A;  // *
  localparam logic [7:0] ChAdd   = 8'h2B;  // +
  localparam logic [7:0] ChSub   = 8'h2D;  // -
  localparam logic [7:0] ChDiv   = 8'h2F;  // /
  localparam logic [7:0] ChPow   = 8'h5E;  // ^

  function automatic logic [2:0] prio(input logic [7:0] c);
    logic [2:0] p;
    case (c)
      ChPow:         p = 3'd4;
      ChMul, ChDiv:  p = 3'd3;
      ChAdd, ChSub:  p = 3'd2;
      ChOpen:        p = 3'd1;
      default:       p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return c == ChAdd || c == ChSub || c == ChMul || c == ChDiv || c == ChPow;
  endfunction

endpackage

>>> src/itp_stack.sv
// Operator stack storage: synchronous memory with one write port and one
// registered read port, write-to-read forwarding. Uses no package.
`timescale 1ns / 1ps

module itp_stack #(
  parameter int Depth = 32,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // forward a same-cycle write so the top entry is never stale
  always_ff @(posedge clk_i) begin
    if (we_i && re_i && waddr_i == raddr_i) begin
      rdata_q <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/infix_to_postfix_converter.sv
// Infix-to-postfix converter top level: handshake, sequencer and output
// register. Depends on itp_pkg and itp_stack.
`timescale 1ns / 1ps

// Shunting-yard converter. One character item is taken per accepted input;
// the block then works on it alone and takes the next item once done. After
// an item is accepted, the block pops operators to the output or drops '('
// entries one at a time, then ends with a closing step that pushes, emits the
// item's own result or drops it. A ')' instead ends on the step that pops its
// '('. A plain operand or an ignored character goes straight to its closing
// step. The operator stack lives in a single-port-write, registered-read memory
// whose read port always holds the current top entry, so a pop needs no
// separate read step. A cycle that emits waits while the output register still
// holds a stalled result. The output register lets a finished result wait while
// the next item is accepted.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  itp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output itp_pkg::out_item_t out_item_o
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StWork = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic                op_q;
  logic [7:0]          sym_q;
  logic [CW-1:0]       count_q, count_d;
  logic                open_q, open_d;
  logic                out_valid_q, out_valid_d;
  itp_pkg::out_item_t  out_q, out_d;

  logic                we;
  logic [7:0]          top;
  logic [CW-1:0]       cnt_m1;
  logic                empty, full, out_free, accept;

  assign accept   = in_valid_i && state_q == StIdle;
  assign empty    = count_q == '0;
  assign full     = count_q == CW'(STACK_DEPTH);
  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_m1   = count_d - 1'b1;

  itp_stack #(
    .Depth(STACK_DEPTH),
    .AW   (AW)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(sym_q),
    .re_i   (count_d != '0),
    .raddr_i(cnt_m1[AW-1:0]),
    .rdata_o(top)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    open_d      = open_q;
    we          = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (state_q == StIdle) begin
      if (accept) begin
        state_d = StWork;
      end
    end else begin
      if (op_q) begin
        // flush: drop '(' silently, emit the rest, then the done item
        if (!empty) begin
          if (top == itp_pkg::ChOpen) begin
            count_d = count_q - 1'b1;
            open_d  = 1'b1;
          end else if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{top, itp_pkg::StatusOk, 1'b0};
            count_d     = count_q - 1'b1;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{8'h00, open_q ? itp_pkg::StatusNoClose : itp_pkg::StatusOk, 1'b1};
          open_d      = 1'b0;
          state_d     = StIdle;
        end
      end else if (itp_pkg::is_operand(sym_q)) begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{sym_q, itp_pkg::StatusOk, 1'b0};
          state_d     = StIdle;
        end
      end else if (sym_q == itp_pkg::ChClose) begin
        if (!empty) begin
          if (top == itp_pkg::ChOpen) begin
            count_d = count_q - 1'b1;
            state_d = StIdle;
          end else if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{top, itp_pkg::StatusOk, 1'b0};
            count_d     = count_q - 1'b1;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{sym_q, itp_pkg::StatusNoOpen, 1'b0};
          state_d     = StIdle;
        end
      end else if (sym_q == itp_pkg::ChOpen || itp_pkg::is_operator(sym_q)) begin
        if (!empty && sym_q != itp_pkg::ChOpen &&
            itp_pkg::prio(top) >= itp_pkg::prio(sym_q)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{top, itp_pkg::StatusOk, 1'b0};
            count_d     = count_q - 1'b1;
          end
        end else if (full) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{sym_q, itp_pkg::StatusOverflow, 1'b0};
            state_d     = StIdle;
          end
        end else begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
          state_d = StIdle;
        end
      end else begin
        // drop anything else
        state_d = StIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      op_q  <= in_item_i.op;
      sym_q <= in_item_i.symbol;
    end
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for infix_to_postfix_converter: directed and random
// expression items with a shunting-yard scoreboard. Depends on itp_pkg.
`timescale 1ns / 1ps

module testbench;

  localparam int          STACK_DEPTH  = 32;
  localparam int          RANDOM_ITEMS = 270;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          MAX_REPORTS  = 10;
  localparam logic        OpChar       = 1'b0;
  localparam logic        OpEnd        = 1'b1;
  localparam logic [7:0]  ChLowerA     = 8'h61;
  localparam logic [7:0]  ChUpperA     = 8'h41;
  localparam logic [7:0]  ChZero       = 8'h30;
  localparam logic [7:0]  ChNone       = 8'h00;

  // Shunting-yard predictor with its own operator stack and result queue.
  class postfix_scoreboard;
    logic [7:0]         op_stack [STACK_DEPTH];
    int                 depth;
    itp_pkg::out_item_t postfix_q [$];
    int                 failures;

    function new();
      depth    = 0;
      failures = 0;
    endfunction

    function int precedence(logic [7:0] c);
      if (c == itp_pkg::ChPow) return 4;
      if (c == itp_pkg::ChMul || c == itp_pkg::ChDiv) return 3;
      if (c == itp_pkg::ChAdd || c == itp_pkg::ChSub) return 2;
      if (c == itp_pkg::ChOpen) return 1;
      return 0;
    endfunction

    function bit is_symbol_char(logic [7:0] c);
      return (c >= ChLowerA && c < ChLowerA + 8'd26) ||
             (c >= ChUpperA && c < ChUpperA + 8'd26) ||
             (c >= ChZero && c < ChZero + 8'd10);
    endfunction

    // True when the item changes state or gives a result.
    function bit handles(itp_pkg::in_item_t it);
      return it.op == OpEnd || is_symbol_char(it.symbol) ||
             it.symbol == itp_pkg::ChOpen || it.symbol == itp_pkg::ChClose ||
             precedence(it.symbol) >= 2;
    endfunction

    function int pending();
      return postfix_q.size();
    endfunction

    function void emit(logic [7:0] sym, logic [1:0] st, logic dn);
      itp_pkg::out_item_t r;
      r.out_symbol = sym;
      r.status     = st;
      r.done_res   = dn;
      postfix_q.push_back(r);
    endfunction

    function void push_or_drop(logic [7:0] c);
      if (depth >= STACK_DEPTH) begin
        emit(c, itp_pkg::StatusOverflow, 1'b0);
      end else begin
        op_stack[depth] = c;
        depth++;
      end
    endfunction

    function void note_item(itp_pkg::in_item_t it);
      logic [7:0] c;
      bit         seen_open;
      c = it.symbol;
      seen_open = 1'b0;
      if (it.op == OpEnd) begin
        // flush: drop leftover opens, emit operators
        while (depth > 0) begin
          depth--;
          if (op_stack[depth] == itp_pkg::ChOpen) seen_open = 1'b1;
          else emit(op_stack[depth], itp_pkg::StatusOk, 1'b0);
        end
        emit(ChNone, seen_open ? itp_pkg::StatusNoClose : itp_pkg::StatusOk, 1'b1);
      end else if (is_symbol_char(c)) begin
        emit(c, itp_pkg::StatusOk, 1'b0);
      end else if (c == itp_pkg::ChOpen) begin
        push_or_drop(c);
      end else if (c == itp_pkg::ChClose) begin
        while (depth > 0 && !seen_open) begin
          depth--;
          if (op_stack[depth] == itp_pkg::ChOpen) seen_open = 1'b1;
          else emit(op_stack[depth], itp_pkg::StatusOk, 1'b0);
        end
        if (!seen_open) emit(c, itp_pkg::StatusNoOpen, 1'b0);
      end else if (precedence(c) >= 2) begin
        while (depth > 0 && precedence(op_stack[depth - 1]) >= precedence(c)) begin
          depth--;
          emit(op_stack[depth], itp_pkg::StatusOk, 1'b0);
        end
        push_or_drop(c);
      end
    endfunction

    function void check_result(itp_pkg::out_item_t got);
      itp_pkg::out_item_t want;
      if (postfix_q.size() == 0) begin
        if (failures < MAX_REPORTS)
          $display("unexpected result: sym %h status %0d done %0b",
                   got.out_symbol, got.status, got.done_res);
        failures++;
        return;
      end
      want = postfix_q.pop_front();
      if (got.out_symbol !== want.out_symbol || got.status !== want.status ||
          got.done_res !== want.done_res) begin
        if (failures < MAX_REPORTS)
          $display("result mismatch: expected sym %h status %0d done %0b, %s",
                   want.out_symbol, want.status, want.done_res,
                   $sformatf("got sym %h status %0d done %0b",
                             got.out_symbol, got.status, got.done_res));
        failures++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  itp_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  itp_pkg::out_item_t out_item_o;

  postfix_scoreboard  sb = new();
  bit                 calm = 1'b0;
  int                 stall_left = 0;
  int                 cycle_count = 0;
  int                 items_done = 0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: check each accepted item, then stall for a random stretch.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_item_o);
      stall_left = calm ? 0 : $urandom_range(0, 16);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  task automatic send_item(logic op_b, logic [7:0] sym);
    itp_pkg::in_item_t it;
    int                gap;
    it.op     = op_b;
    it.symbol = sym;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    if (sb.handles(it)) items_done++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(OpChar, s[i]);
  endtask

  // Hold off the sender until every expected result is back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 2))
      0:       return ChLowerA + 8'($urandom_range(0, 25));
      1:       return ChUpperA + 8'($urandom_range(0, 25));
      default: return ChZero + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return itp_pkg::ChAdd;
      1:       return itp_pkg::ChSub;
      2:       return itp_pkg::ChMul;
      3:       return itp_pkg::ChDiv;
      default: return itp_pkg::ChPow;
    endcase
  endfunction

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 5))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return itp_pkg::ChOpen;
      3:       return itp_pkg::ChClose;
      4:       return pick_operator();
      default: return pick_operand();
    endcase
  endfunction

  task automatic send_well_formed();
    int terms;
    int open;
    terms = $urandom_range(1, 7);
    open  = 0;
    for (int t = 0; t < terms; t++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_item(OpChar, itp_pkg::ChOpen);
        open++;
      end
      send_item(OpChar, pick_operand());
      if (open > 0 && $urandom_range(0, 2) == 0) begin
        send_item(OpChar, itp_pkg::ChClose);
        open--;
      end
      if (t < terms - 1) send_item(OpChar, pick_operator());
    end
    while (open > 0) begin
      send_item(OpChar, itp_pkg::ChClose);
      open--;
    end
    send_item(OpEnd, 8'($urandom_range(0, 255)));
  endtask

  // Nest deeply to reach overflow, then close a random number of levels.
  task automatic send_deep();
    int steps;
    int closes;
    steps = $urandom_range(20, 48);
    for (int k = 0; k < steps; k++) begin
      if ($urandom_range(0, 2) != 0) begin
        send_item(OpChar, itp_pkg::ChOpen);
      end else begin
        send_item(OpChar, pick_operand());
        send_item(OpChar, pick_operator());
      end
    end
    send_item(OpChar, pick_operand());
    closes = $urandom_range(0, steps + 2);
    repeat (closes) send_item(OpChar, itp_pkg::ChClose);
    send_item(OpEnd, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(1, 12);
    repeat (len) begin
      if ($urandom_range(0, 9) == 0) send_item(OpEnd, 8'($urandom_range(0, 255)));
      else send_item(OpChar, pick_noise());
    end
    send_item(OpEnd, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int mode;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ignored extremes, every operator, unmatched close, leftover open
    send_item(OpChar, 8'h00);
    send_item(OpChar, 8'hFF);
    send_text("a+b*c-d/e^f^g");
    send_item(OpEnd, 8'hFF);
    send_text("(0+Z)^9)(");
    send_item(OpEnd, 8'h00);
    wait_drained();

    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      mode = $urandom_range(0, 9);
      if (mode < 6) send_well_formed();
      else if (mode < 8) send_deep();
      else send_noise();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
